[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define ASSERT_CLK(label, clock, rstn, prop, msg) \
  label: assert property (@(posedge clock) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked implication, off while reset is held.
`define ASSERT_IMPL(label, clock, rstn, pre, post, msg) \
  label: assert property (@(posedge clock) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error(msg);

`endif

[rtl/cdtd_pkg.sv]
// Constants and types for the color difference threshold dilation block.
package cdtd_pkg;

  localparam int MAX_COLS_DEFAULT = 2048;

  // Register widths
  localparam int CFG_W   = 12;
  localparam int PIX_W   = 8;
  localparam int ROW_W   = 13;
  localparam int CADDR_W = 2;

  // Register indexes
  localparam logic [CADDR_W-1:0] REG_FRAME_ROWS = 2'd0;
  localparam logic [CADDR_W-1:0] REG_FRAME_COLS = 2'd1;
  localparam logic [CADDR_W-1:0] REG_LEVEL      = 2'd2;
  localparam logic [CADDR_W-1:0] REG_SET_VALUE  = 2'd3;

  // Request kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_PAD   = 1'b1;

  // Reset values
  localparam logic [CFG_W-1:0] FRAME_ROWS_RST = 12'd720;
  localparam logic [CFG_W-1:0] FRAME_COLS_RST = 12'd1280;
  localparam logic [PIX_W-1:0] LEVEL_RST      = 8'd0;
  localparam logic [PIX_W-1:0] SET_VALUE_RST  = 8'd255;

  // Position flags of a request held in the window stage
  typedef struct packed {
    logic cur;      // threshold bit of this pixel
    logic first;    // column 0
    logic row_nz;   // row index above 0
    logic row_end;  // last column of the row
    logic pad;      // padding row
  } s1_ctrl_t;

endpackage

[rtl/color_difference_threshold_dilate.sv]
// Top level: blue minus red threshold followed by a 3x3 binary dilation.
// A request is held in the window stage, then each result in the output register.
// Throughput: one request per cycle unless the output stalls; outside row 0 the last
//   column of a row of two or more columns yields two results, holding the input for both.
// Set by the single output register draining at most one result per cycle.
// Reset (rst_n low, synchronous): counters, window, valid flags and registers back to
//   defaults; the line store is not cleared, row 0 masks its contents.
`include "assert_macros.svh"

module color_difference_threshold_dilate #(
  parameter int MAX_COLS = cdtd_pkg::MAX_COLS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] blue, [15:8] red
  input  logic        in_tuser,   // [0] kind: 0 pixel, 1 padding tick
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] pixel_out
  output logic        out_tlast,  // run_last: last result of its request
  output logic        out_tuser,  // [0] frame_last
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [11:0] cfg_wdata
);
  import cdtd_pkg::*;

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] frame_rows_r, frame_cols_r;
  logic [PIX_W-1:0] level_r, set_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r <= FRAME_ROWS_RST;
      frame_cols_r <= FRAME_COLS_RST;
      level_r      <= LEVEL_RST;
      set_value_r  <= SET_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_ROWS: frame_rows_r <= cfg_wdata;
        REG_FRAME_COLS: frame_cols_r <= cfg_wdata;
        REG_LEVEL:      level_r      <= cfg_wdata[PIX_W-1:0];
        REG_SET_VALUE:  set_value_r  <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp out-of-range sizes: zero acts as one, columns cap at the store depth.
  logic [EW-1:0]    cols_eff;
  logic [CFG_W-1:0] rows_eff;

  always_comb begin
    if (frame_cols_r == '0) begin
      cols_eff = EW'(1);
    end else if (EW'(frame_cols_r) > EW'(MAX_COLS)) begin
      cols_eff = EW'(MAX_COLS);
    end else begin
      cols_eff = EW'(frame_cols_r);
    end
    rows_eff = (frame_rows_r == '0) ? CFG_W'(1) : frame_rows_r;
  end

  // ------------------------------------------------------- input position
  logic [ROW_W-1:0] row_index_r;
  logic [CW-1:0]    col_index_r;
  logic             pad_row, row_end, cur_bit, in_fire;
  logic [PIX_W-1:0] diff;

  assign pad_row = row_index_r >= ROW_W'(rows_eff);
  assign row_end = (EW'(col_index_r) + EW'(1)) >= cols_eff;
  assign diff    = in_tdata[7:0] - in_tdata[15:8];  // wraps mod 256
  assign cur_bit = !pad_row && (in_tuser == KIND_PIXEL) && (diff > level_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_index_r <= '0;
      col_index_r <= '0;
    end else if (in_fire) begin
      if (row_end) begin
        col_index_r <= '0;
        row_index_r <= pad_row ? '0 : row_index_r + ROW_W'(1);
      end else begin
        col_index_r <= col_index_r + CW'(1);
      end
    end
  end

  // --------------------------------------------------------- window stage
  logic           s1_v_r, phase_r;
  s1_ctrl_t       s1_r;
  logic [CW-1:0]  s1_addr_r;
  logic [1:0]     mem_q_r, byp_d_r, mem_word, wr_word;
  logic           byp_v_r;
  logic [5:0]     win_r;
  logic [2:0]     curcol, prev1, prev2;
  logic           r0v, r1v, r0_set, r1_set, slot_free, emit, retire, sel1;

  // Line store: bit 1 the older row, bit 0 the newer row.
  logic [1:0] line_mem [MAX_COLS];

  // Same-column write and read in one cycle happens only for one-column rows.
  assign mem_word = byp_v_r ? byp_d_r : mem_q_r;
  assign curcol   = {s1_r.row_nz & mem_word[1], s1_r.row_nz & mem_word[0], s1_r.cur};
  assign wr_word  = {curcol[1], s1_r.cur};
  assign prev1    = s1_r.first ? 3'b000 : win_r[2:0];
  assign prev2    = s1_r.first ? 3'b000 : win_r[5:3];
  assign r0v      = s1_r.row_nz && !s1_r.first;
  assign r1v      = s1_r.row_nz && s1_r.row_end;
  assign r0_set   = |(prev2 | prev1 | curcol);
  assign r1_set   = |(prev1 | curcol);
  assign slot_free = !out_tvalid || out_tready;

  // phase_r set: first of two results sent, the row-end one remains.
  always_comb begin
    emit   = 1'b0;
    retire = 1'b0;
    sel1   = 1'b0;
    if (s1_v_r) begin
      if (phase_r) begin
        sel1   = 1'b1;
        emit   = slot_free;
        retire = slot_free;
      end else if (r0v) begin
        emit   = slot_free;
        retire = slot_free && !r1v;
      end else if (r1v) begin
        sel1   = 1'b1;
        emit   = slot_free;
        retire = slot_free;
      end else begin
        retire = 1'b1;
      end
    end
  end

  assign in_tready = !s1_v_r || retire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      phase_r <= 1'b0;
      byp_v_r <= 1'b0;
      win_r   <= '0;
    end else begin
      if (in_fire) begin
        s1_v_r  <= 1'b1;
        byp_v_r <= retire && (col_index_r == s1_addr_r);
      end else if (retire) begin
        s1_v_r <= 1'b0;
      end
      if (retire) begin
        phase_r <= 1'b0;
        win_r   <= s1_r.row_end ? 6'b000000 : {prev1, curcol};
      end else if (emit) begin
        phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.cur     <= cur_bit;
      s1_r.first   <= (col_index_r == '0);
      s1_r.row_nz  <= (row_index_r != '0);
      s1_r.row_end <= row_end;
      s1_r.pad     <= pad_row;
      s1_addr_r    <= col_index_r;
      byp_d_r      <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      line_mem[s1_addr_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_q_r <= line_mem[col_index_r];
    end
  end

  // ------------------------------------------------------- output register
  logic             out_v_r, out_last_r, out_frame_r;
  logic [PIX_W-1:0] out_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (emit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pix_r   <= (sel1 ? r1_set : r0_set) ? set_value_r : '0;
      out_last_r  <= sel1 || !r1v;
      out_frame_r <= sel1 && s1_r.pad;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_frame_r;

  // ------------------------------------------------------------ assertions
  `ASSERT_IMPL(a_phase_held, clk, rst_n, phase_r, s1_v_r, "second result pending with empty stage")
  `ASSERT_IMPL(a_frame_last, clk, rst_n, out_tvalid && out_tuser, out_tlast,
               "frame end not on the last result of its request")
  `ASSERT_CLK(a_col_range, clk, rst_n,
              EW'(col_index_r) < cols_eff || EW'(col_index_r) < EW'(MAX_COLS),
              "column index beyond the line store")

endmodule
